>>> hdl/assert_macros.svh
// Assertion macros for the checker file nkvl_checker.sv.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define NKVL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define NKVL_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> hdl/nkvl_pkg.sv
// Shared codes, character classes and the whitespace-state decoder
// for the nested key/value lexer. No dependencies.
package nkvl_pkg;

    localparam int LINE_BITS_DEF  = 20;
    localparam int DEPTH_BITS_DEF = 8;
    localparam logic [7:0] MAX_DEPTH_RST = 8'd255;

    // lexer modes
    localparam logic [2:0] M_WS      = 3'd0;
    localparam logic [2:0] M_COMMENT = 3'd1;
    localparam logic [2:0] M_NAME    = 3'd2;
    localparam logic [2:0] M_STRING  = 3'd3;
    localparam logic [2:0] M_ESCAPE  = 3'd4;
    localparam logic [2:0] M_NUMBER  = 3'd5;
    localparam logic [2:0] M_ERROR   = 3'd6;
    localparam logic [2:0] M_END     = 3'd7;

    // event codes
    localparam logic [3:0] EV_NONE       = 4'd0;
    localparam logic [3:0] EV_NAME_FIRST = 4'd1;
    localparam logic [3:0] EV_NAME_CHAR  = 4'd2;
    localparam logic [3:0] EV_NAME_END   = 4'd3;
    localparam logic [3:0] EV_STR_OPEN   = 4'd4;
    localparam logic [3:0] EV_STR_CHAR   = 4'd5;
    localparam logic [3:0] EV_STR_CLOSE  = 4'd6;
    localparam logic [3:0] EV_NUM_FIRST  = 4'd7;
    localparam logic [3:0] EV_NUM_CHAR   = 4'd8;
    localparam logic [3:0] EV_NUM_END    = 4'd9;
    localparam logic [3:0] EV_OPEN       = 4'd10;
    localparam logic [3:0] EV_CLOSE      = 4'd11;
    localparam logic [3:0] EV_DONE       = 4'd12;
    localparam logic [3:0] EV_ERROR      = 4'd13;

    // error kinds
    localparam logic [2:0] ER_NONE   = 3'd0;
    localparam logic [2:0] ER_CHAR   = 3'd1;
    localparam logic [2:0] ER_END    = 3'd2;
    localparam logic [2:0] ER_CLOSE  = 3'd3;
    localparam logic [2:0] ER_ESCAPE = 3'd4;
    localparam logic [2:0] ER_DEEP   = 3'd5;

    // characters
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_X  = 8'h78;
    localparam logic [7:0] CH_LOW_E  = 8'h65;
    localparam logic [7:0] CH_UP_E   = 8'h45;

    typedef struct packed {
        logic [3:0] ev;
        logic [7:0] data;
        logic [2:0] err;
        logic [2:0] mode;
        logic       inc;
        logic       dec;
    } ws_res_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_xdigit(input logic [7:0] c);
        return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic is_print(input logic [7:0] c);
        return c >= 8'h20 && c <= 8'h7E;
    endfunction

    // Decode one character (or end mark) in whitespace mode.
    function automatic ws_res_t lex_ws(input logic [7:0] c, input logic eof,
                                       input logic dep_zero, input logic at_limit);
        ws_res_t r;
        r = '{ev: EV_NONE, data: 8'd0, err: ER_NONE, mode: M_WS, inc: 1'b0, dec: 1'b0};
        if (eof) begin
            if (dep_zero) begin
                r.ev = EV_DONE;
                r.mode = M_END;
            end else begin
                r.ev = EV_ERROR;
                r.err = ER_END;
                r.mode = M_ERROR;
            end
        end else if (c == CH_HASH) begin
            r.mode = M_COMMENT;
        end else if (is_alpha(c) || c == CH_UNDER) begin
            r.ev = EV_NAME_FIRST;
            r.data = c;
            r.mode = M_NAME;
        end else if (c == CH_PLUS || c == CH_MINUS || c == CH_DOT || is_digit(c)) begin
            r.ev = EV_NUM_FIRST;
            r.data = c;
            r.mode = M_NUMBER;
        end else if (c == CH_QUOTE) begin
            r.ev = EV_STR_OPEN;
            r.mode = M_STRING;
        end else if (c == CH_LBRACE) begin
            if (at_limit) begin
                r.ev = EV_ERROR;
                r.err = ER_DEEP;
                r.mode = M_ERROR;
            end else begin
                r.ev = EV_OPEN;
                r.inc = 1'b1;
            end
        end else if (c == CH_RBRACE) begin
            if (!dep_zero) begin
                r.ev = EV_CLOSE;
                r.dec = 1'b1;
            end else begin
                r.ev = EV_ERROR;
                r.err = ER_CLOSE;
                r.mode = M_ERROR;
            end
        end else if (!is_space(c)) begin
            r.ev = EV_ERROR;
            r.err = ER_CHAR;
            r.mode = M_ERROR;
        end
        return r;
    endfunction

endpackage

>>> hdl/nested_keyvalue_lexer.sv
// Nested key/value text lexer, top level.
// Depends on nkvl_pkg.
//
// Usage:
//  - s_ channel: one transfer per input byte. s_tdata holds ch, s_tuser
//    holds end_of_input (ch is ignored when it is set).
//  - m_ channel: token events. s_tdata byte -> one or two result transfers;
//    m_tlast marks the final result of each input byte.
//  - cfg_we/cfg_wdata write max_depth; write only while the block is idle.
//  - A byte is decoded straight out of the input register; its results are
//    registered in the result register, which drives m_.
//  - Throughput: one byte per cycle while m_tready is high. A byte that ends
//    a name or a number yields two results and holds the result register
//    until the second one is taken, which also slows the rate.
//  - Stall: while m_tready is low, results hold and the input register can
//    still take one more byte before s_tready drops.
//  - Reset (aresetn low, synchronous): both registers empty, whitespace
//    mode, depth 0, line 1, max_depth 255. No clearing pass.
//  - After done or an error every further byte repeats that same result.
module nested_keyvalue_lexer #(
    parameter int LINE_BITS  = nkvl_pkg::LINE_BITS_DEF,
    parameter int DEPTH_BITS = nkvl_pkg::DEPTH_BITS_DEF,
    localparam int OUT_BITS  = 23 + LINE_BITS,
    localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    // input channel
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [7:0] ch
    input  logic             s_tuser,   // [0] end_of_input
    // result channel
    output logic             m_tvalid,
    input  logic             m_tready,
    // [3:0] event_res, [11:4] data_byte, [14:12] error_kind,
    // [14+LINE_BITS:15] line_number, next 8 bits depth, rest zero
    output logic [OUT_W-1:0] m_tdata,
    output logic             m_tlast,   // last
    // configuration
    input  logic             cfg_we,
    input  logic [7:0]       cfg_wdata  // max_depth
);

    localparam int LIM_W = (DEPTH_BITS > 8) ? DEPTH_BITS : 8;
    localparam logic [LINE_BITS-1:0] LINE_TOP = {LINE_BITS{1'b1}};

    // input register
    logic                  in_valid_reg;
    logic [7:0]            in_ch_reg;
    logic                  in_eof_reg;

    // lexer state
    logic [2:0]            mode_reg, mode_next;
    logic [DEPTH_BITS-1:0] depth_reg, depth_next;
    logic [LINE_BITS-1:0]  line_reg, line_next;
    logic                  prev_cr_reg, prev_cr_next;
    logic [2:0]            err_reg;
    logic [7:0]            max_depth_reg;

    // result register: slot 0 on the bus, slot 1 waiting
    logic [1:0]            cnt_reg;
    logic [OUT_W-1:0]      slot0_reg, slot1_reg;
    logic                  last0_reg;

    logic                  out_free, advance, two;
    logic [7:0]            c;
    logic [LINE_BITS-1:0]  line_after;
    logic [LIM_W-1:0]      limit;
    logic                  at_limit;
    logic [DEPTH_BITS-1:0] ws_depth;
    nkvl_pkg::ws_res_t     ws;

    logic [3:0]            r0_ev, r1_ev;
    logic [7:0]            r0_data, r1_data;
    logic [2:0]            r0_err, r1_err;
    logic [LINE_BITS-1:0]  r0_line;
    logic [DEPTH_BITS-1:0] r0_dep;
    logic [OUT_W-1:0]      r0_pk, r1_pk;

    assign out_free = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_tready);
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = slot0_reg;
    assign m_tlast  = last0_reg;

    // overflow limit: the smaller of max_depth and the counter top
    always_comb begin
        limit = (LIM_W'(max_depth_reg) < LIM_W'({DEPTH_BITS{1'b1}}))
              ? LIM_W'(max_depth_reg) : LIM_W'({DEPTH_BITS{1'b1}});
        at_limit = LIM_W'(depth_reg) >= limit;
    end

    always_comb begin
        c = (in_ch_reg == nkvl_pkg::CH_CR) ? nkvl_pkg::CH_LF : in_ch_reg;
        line_after = (!in_eof_reg && c == nkvl_pkg::CH_LF && line_reg != LINE_TOP)
                   ? line_reg + LINE_BITS'(1) : line_reg;
        ws = nkvl_pkg::lex_ws(c, in_eof_reg, depth_reg == '0, at_limit);
        ws_depth = ws.inc ? depth_reg + DEPTH_BITS'(1)
                 : ws.dec ? depth_reg - DEPTH_BITS'(1) : depth_reg;

        mode_next    = mode_reg;
        depth_next   = depth_reg;
        line_next    = line_reg;
        prev_cr_next = prev_cr_reg;
        two          = 1'b0;
        r0_ev   = nkvl_pkg::EV_NONE;
        r0_data = 8'd0;
        r0_err  = nkvl_pkg::ER_NONE;
        r0_line = line_reg;
        r0_dep  = depth_reg;
        r1_ev   = ws.ev;
        r1_data = ws.data;
        r1_err  = ws.err;

        if (mode_reg == nkvl_pkg::M_ERROR) begin
            r0_ev  = nkvl_pkg::EV_ERROR;
            r0_err = err_reg;
        end else if (mode_reg == nkvl_pkg::M_END) begin
            r0_ev = nkvl_pkg::EV_DONE;
        end else if (!in_eof_reg && prev_cr_reg && in_ch_reg == nkvl_pkg::CH_LF) begin
            // LF of a CRLF pair: already counted
            prev_cr_next = 1'b0;
        end else begin
            prev_cr_next = !in_eof_reg && in_ch_reg == nkvl_pkg::CH_CR;
            line_next    = line_after;
            r0_line      = line_after;
            unique case (mode_reg)
                nkvl_pkg::M_COMMENT: begin
                    if (in_eof_reg) begin
                        r0_ev = ws.ev;
                        r0_err = ws.err;
                        mode_next = ws.mode;
                    end else if (c == nkvl_pkg::CH_LF) begin
                        mode_next = nkvl_pkg::M_WS;
                    end
                end
                nkvl_pkg::M_NAME: begin
                    if (in_eof_reg) begin
                        r0_ev = nkvl_pkg::EV_ERROR;
                        r0_err = nkvl_pkg::ER_END;
                        mode_next = nkvl_pkg::M_ERROR;
                    end else if (c == nkvl_pkg::CH_UNDER || nkvl_pkg::is_alpha(c)
                                 || nkvl_pkg::is_digit(c)) begin
                        r0_ev = nkvl_pkg::EV_NAME_CHAR;
                        r0_data = c;
                    end else if (nkvl_pkg::is_space(c) || c == nkvl_pkg::CH_LBRACE
                                 || c == nkvl_pkg::CH_RBRACE) begin
                        two = 1'b1;
                        r0_ev = nkvl_pkg::EV_NAME_END;
                        r0_line = line_reg;
                        mode_next = ws.mode;
                        depth_next = ws_depth;
                    end else begin
                        r0_ev = nkvl_pkg::EV_ERROR;
                        r0_err = nkvl_pkg::ER_CHAR;
                        mode_next = nkvl_pkg::M_ERROR;
                    end
                end
                nkvl_pkg::M_NUMBER: begin
                    if (!in_eof_reg && (nkvl_pkg::is_xdigit(c) || c == nkvl_pkg::CH_LOW_X
                        || c == nkvl_pkg::CH_DOT || c == nkvl_pkg::CH_LOW_E
                        || c == nkvl_pkg::CH_UP_E || c == nkvl_pkg::CH_PLUS
                        || c == nkvl_pkg::CH_MINUS)) begin
                        r0_ev = nkvl_pkg::EV_NUM_CHAR;
                        r0_data = c;
                    end else if (in_eof_reg || nkvl_pkg::is_space(c)
                                 || c == nkvl_pkg::CH_LBRACE
                                 || c == nkvl_pkg::CH_RBRACE) begin
                        two = 1'b1;
                        r0_ev = nkvl_pkg::EV_NUM_END;
                        r0_line = line_reg;
                        mode_next = ws.mode;
                        depth_next = ws_depth;
                    end else begin
                        r0_ev = nkvl_pkg::EV_ERROR;
                        r0_err = nkvl_pkg::ER_CHAR;
                        mode_next = nkvl_pkg::M_ERROR;
                    end
                end
                nkvl_pkg::M_STRING: begin
                    if (in_eof_reg) begin
                        r0_ev = nkvl_pkg::EV_ERROR;
                        r0_err = nkvl_pkg::ER_END;
                        mode_next = nkvl_pkg::M_ERROR;
                    end else if (c == nkvl_pkg::CH_BSLASH) begin
                        mode_next = nkvl_pkg::M_ESCAPE;
                    end else if (c == nkvl_pkg::CH_QUOTE) begin
                        r0_ev = nkvl_pkg::EV_STR_CLOSE;
                        mode_next = nkvl_pkg::M_WS;
                    end else if (nkvl_pkg::is_print(c)) begin
                        r0_ev = nkvl_pkg::EV_STR_CHAR;
                        r0_data = c;
                    end else begin
                        r0_ev = nkvl_pkg::EV_ERROR;
                        r0_err = nkvl_pkg::ER_CHAR;
                        mode_next = nkvl_pkg::M_ERROR;
                    end
                end
                nkvl_pkg::M_ESCAPE: begin
                    r0_ev = nkvl_pkg::EV_STR_CHAR;
                    mode_next = nkvl_pkg::M_STRING;
                    if (in_eof_reg) begin
                        r0_ev = nkvl_pkg::EV_ERROR;
                        r0_err = nkvl_pkg::ER_ESCAPE;
                        mode_next = nkvl_pkg::M_ERROR;
                    end else if (c == nkvl_pkg::CH_LOW_T) begin
                        r0_data = nkvl_pkg::CH_TAB;
                    end else if (c == nkvl_pkg::CH_LOW_R) begin
                        r0_data = nkvl_pkg::CH_CR;
                    end else if (c == nkvl_pkg::CH_LOW_N) begin
                        r0_data = nkvl_pkg::CH_LF;
                    end else if (c == nkvl_pkg::CH_QUOTE || c == nkvl_pkg::CH_BSLASH) begin
                        r0_data = c;
                    end else begin
                        r0_ev = nkvl_pkg::EV_ERROR;
                        r0_err = nkvl_pkg::ER_ESCAPE;
                        mode_next = nkvl_pkg::M_ERROR;
                    end
                end
                default: begin
                    // whitespace mode
                    r0_ev = ws.ev;
                    r0_data = ws.data;
                    r0_err = ws.err;
                    r0_dep = ws_depth;
                    mode_next = ws.mode;
                    depth_next = ws_depth;
                end
            endcase
        end
    end

    // pack results onto the bus layout
    always_comb begin
        r0_pk = '0;
        r0_pk[3:0]   = r0_ev;
        r0_pk[11:4]  = r0_data;
        r0_pk[14:12] = r0_err;
        r0_pk[15 +: LINE_BITS] = r0_line;
        r0_pk[15 + LINE_BITS +: 8] = 8'(r0_dep);
        r1_pk = '0;
        r1_pk[3:0]   = r1_ev;
        r1_pk[11:4]  = r1_data;
        r1_pk[14:12] = r1_err;
        r1_pk[15 +: LINE_BITS] = line_after;
        r1_pk[15 + LINE_BITS +: 8] = 8'(ws_depth);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            cnt_reg       <= 2'd0;
            mode_reg      <= nkvl_pkg::M_WS;
            depth_reg     <= '0;
            line_reg      <= LINE_BITS'(1);
            prev_cr_reg   <= 1'b0;
            err_reg       <= nkvl_pkg::ER_NONE;
            max_depth_reg <= nkvl_pkg::MAX_DEPTH_RST;
        end else begin
            if (cfg_we) begin
                max_depth_reg <= cfg_wdata;
            end

            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                cnt_reg     <= two ? 2'd2 : 2'd1;
                mode_reg    <= mode_next;
                depth_reg   <= depth_next;
                line_reg    <= line_next;
                prev_cr_reg <= prev_cr_next;
                if (two && r1_ev == nkvl_pkg::EV_ERROR) begin
                    err_reg <= r1_err;
                end else if (!two && r0_ev == nkvl_pkg::EV_ERROR) begin
                    err_reg <= r0_err;
                end
            end else if (m_tvalid && m_tready) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_ch_reg  <= s_tdata;
            in_eof_reg <= s_tuser;
        end
        if (advance) begin
            slot0_reg <= r0_pk;
            last0_reg <= !two;
            slot1_reg <= r1_pk;
        end else if (m_tvalid && m_tready && cnt_reg == 2'd2) begin
            slot0_reg <= slot1_reg;
            last0_reg <= 1'b1;
        end
    end

endmodule

>>> hdl/nkvl_checker.sv
// Port-level checks for nested_keyvalue_lexer, attached by bind.
// Depends on nkvl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module nkvl_checker #(
    parameter int LINE_BITS = nkvl_pkg::LINE_BITS_DEF,
    localparam int OUT_W    = ((23 + LINE_BITS + 7) / 8) * 8
) (
    input logic             aclk,
    input logic             aresetn,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic             m_tlast
);

    logic [3:0] ev;
    logic [7:0] data;
    logic [2:0] err;
    logic       char_ev;

    assign ev   = m_tdata[3:0];
    assign data = m_tdata[11:4];
    assign err  = m_tdata[14:12];
    assign char_ev = ev == nkvl_pkg::EV_NAME_FIRST || ev == nkvl_pkg::EV_NAME_CHAR
                  || ev == nkvl_pkg::EV_STR_CHAR || ev == nkvl_pkg::EV_NUM_FIRST
                  || ev == nkvl_pkg::EV_NUM_CHAR;

    `NKVL_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "result valid after reset")

    `NKVL_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

    `NKVL_ASSERT(a_err_kind, m_tvalid |-> ((ev == nkvl_pkg::EV_ERROR) == (err != nkvl_pkg::ER_NONE)), "error kind does not match event")

    `NKVL_ASSERT(a_data_zero, m_tvalid && !char_ev |-> data == 8'd0, "data byte on a non-character event")

    `NKVL_ASSERT(a_end_last, m_tvalid && (ev == nkvl_pkg::EV_DONE || ev == nkvl_pkg::EV_ERROR) |-> m_tlast, "done or error not last")

endmodule

bind nested_keyvalue_lexer nkvl_checker #(.LINE_BITS(LINE_BITS)) u_nkvl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

>>> tb/tb_top.sv
// Self-checking testbench for nested_keyvalue_lexer: byte stimulus in, token events out.
// Depends on nkvl_pkg for the event, error, mode and character codes.
// Results are predicted per accepted byte and compared field by field.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_W = nkvl_pkg::LINE_BITS_DEF;
    localparam int TDATA_W = ((23 + LINE_W + 7) / 8) * 8;
    localparam logic [LINE_W-1:0] LINE_TOP = {LINE_W{1'b1}};
    localparam int QUIET_LIMIT = 4000;   // cycles with no transfer on either side
    localparam int HOLD_CYCLES = 200;    // long receiver hold-off
    localparam int NEST_SOFT = 12;       // keeps random nesting shallow
    localparam logic [7:0] CH_VT = 8'h0B;
    localparam logic [7:0] CH_FF = 8'h0C;

    // How the run ends; only one terminal case fits in a run since done and
    // error are sticky and reset is never applied again.
    typedef enum int {
        END_DONE, END_EOF_NESTED, END_EOF_NAME, END_EOF_NUMBER, END_EOF_STRING,
        END_EOF_ESCAPE, END_BAD_ESCAPE, END_STRING_CTRL, END_WS_CHAR,
        END_TOKEN_CHAR, END_UNBALANCED, END_TOO_DEEP
    } end_case_t;

    typedef struct packed {
        logic [3:0]        ev;
        logic [7:0]        data;
        logic [2:0]        err;
        logic [LINE_W-1:0] line;
        logic [7:0]        depth;
        logic              last;
    } token_t;

    logic               aclk;
    logic               aresetn = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata = 8'd0;
    logic               s_tuser = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tlast;
    logic               cfg_we = 1'b0;
    logic [7:0]         cfg_wdata = 8'd0;

    // Lexer state as predicted by the testbench
    logic [2:0]        lx_mode = nkvl_pkg::M_WS;
    int                lx_depth = 0;
    logic [LINE_W-1:0] lx_line = LINE_W'(1);
    logic              lx_cr = 1'b0;
    logic [2:0]        lx_err = nkvl_pkg::ER_NONE;
    logic [7:0]        lx_max = nkvl_pkg::MAX_DEPTH_RST;

    token_t pending_tokens[$];
    token_t want_tok;

    int tx_idle_pct = 0;   // sender idle chance per cycle, percent
    int rx_stall_pct = 0;  // receiver stall chance per cycle, percent
    int hold_reqs = 0;     // bumped by the stimulus to start a hold-off
    int hold_seen = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int mismatches = 0;
    int bytes_sent = 0;
    int results_checked = 0;
    end_case_t end_case = END_DONE;

    string name_head = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    string name_tail = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    string num_head = "+-.0123456789";
    string num_tail = "0123456789abcdefABCDEFxeE.+-";
    string esc_chars = "trn\"\\";
    string stray_chars = "!$%&'()*,/:;<=>?@[]^`|~";

    nested_keyvalue_lexer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic logic letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic decimal(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic blank(input logic [7:0] c);
        return c == nkvl_pkg::CH_SPACE || (c >= nkvl_pkg::CH_TAB && c <= nkvl_pkg::CH_CR);
    endfunction

    function automatic logic hexdig(input logic [7:0] c);
        return decimal(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic void push_token(input logic [3:0] ev, input logic [7:0] data,
                                       input logic [2:0] err, input logic [LINE_W-1:0] line);
        pending_tokens.push_back('{ev: ev, data: data, err: err, line: line,
                                   depth: lx_depth[7:0], last: 1'b0});
    endfunction

    function automatic void raise_error(input logic [2:0] kind);
        lx_mode = nkvl_pkg::M_ERROR;
        lx_err = kind;
        push_token(nkvl_pkg::EV_ERROR, 8'd0, kind, lx_line);
    endfunction

    function automatic void finish_input();
        if (lx_depth == 0) begin
            lx_mode = nkvl_pkg::M_END;
            push_token(nkvl_pkg::EV_DONE, 8'd0, nkvl_pkg::ER_NONE, lx_line);
        end else begin
            raise_error(nkvl_pkg::ER_END);
        end
    endfunction

    // One character (or end mark) seen between tokens
    function automatic void lex_between(input logic [7:0] c, input logic eof);
        if (eof) begin
            finish_input();
        end else if (c == nkvl_pkg::CH_HASH) begin
            lx_mode = nkvl_pkg::M_COMMENT;
            push_token(nkvl_pkg::EV_NONE, 8'd0, nkvl_pkg::ER_NONE, lx_line);
        end else if (letter(c) || c == nkvl_pkg::CH_UNDER) begin
            lx_mode = nkvl_pkg::M_NAME;
            push_token(nkvl_pkg::EV_NAME_FIRST, c, nkvl_pkg::ER_NONE, lx_line);
        end else if (c == nkvl_pkg::CH_PLUS || c == nkvl_pkg::CH_MINUS
                     || c == nkvl_pkg::CH_DOT || decimal(c)) begin
            lx_mode = nkvl_pkg::M_NUMBER;
            push_token(nkvl_pkg::EV_NUM_FIRST, c, nkvl_pkg::ER_NONE, lx_line);
        end else if (c == nkvl_pkg::CH_QUOTE) begin
            lx_mode = nkvl_pkg::M_STRING;
            push_token(nkvl_pkg::EV_STR_OPEN, 8'd0, nkvl_pkg::ER_NONE, lx_line);
        end else if (c == nkvl_pkg::CH_LBRACE) begin
            if (lx_depth >= lx_max) begin
                raise_error(nkvl_pkg::ER_DEEP);
            end else begin
                lx_depth++;
                push_token(nkvl_pkg::EV_OPEN, 8'd0, nkvl_pkg::ER_NONE, lx_line);
            end
        end else if (c == nkvl_pkg::CH_RBRACE) begin
            if (lx_depth > 0) begin
                lx_depth--;
                push_token(nkvl_pkg::EV_CLOSE, 8'd0, nkvl_pkg::ER_NONE, lx_line);
            end else begin
                raise_error(nkvl_pkg::ER_CLOSE);
            end
        end else if (blank(c)) begin
            push_token(nkvl_pkg::EV_NONE, 8'd0, nkvl_pkg::ER_NONE, lx_line);
        end else begin
            raise_error(nkvl_pkg::ER_CHAR);
        end
    endfunction

    // Expected tokens for one accepted byte; the final one carries last.
    function automatic void tokenize_byte(input logic [7:0] c_in, input logic eof);
        logic [7:0] c;
        logic [LINE_W-1:0] line_pre;
        logic [7:0] decoded;
        c = c_in;
        if (lx_mode == nkvl_pkg::M_ERROR) begin
            push_token(nkvl_pkg::EV_ERROR, 8'd0, lx_err, lx_line);
        end else if (lx_mode == nkvl_pkg::M_END) begin
            push_token(nkvl_pkg::EV_DONE, 8'd0, nkvl_pkg::ER_NONE, lx_line);
        end else if (!eof && lx_cr && c == nkvl_pkg::CH_LF) begin
            // LF of a CRLF pair is swallowed
            lx_cr = 1'b0;
            push_token(nkvl_pkg::EV_NONE, 8'd0, nkvl_pkg::ER_NONE, lx_line);
        end else begin
            if (eof) begin
                lx_cr = 1'b0;
            end else begin
                lx_cr = (c == nkvl_pkg::CH_CR);
                if (c == nkvl_pkg::CH_CR) c = nkvl_pkg::CH_LF;
            end
            line_pre = lx_line;
            if (!eof && c == nkvl_pkg::CH_LF && lx_line != LINE_TOP) lx_line++;
            case (lx_mode)
                nkvl_pkg::M_COMMENT: begin
                    if (eof) begin
                        finish_input();
                    end else begin
                        if (c == nkvl_pkg::CH_LF) lx_mode = nkvl_pkg::M_WS;
                        push_token(nkvl_pkg::EV_NONE, 8'd0, nkvl_pkg::ER_NONE, lx_line);
                    end
                end
                nkvl_pkg::M_NAME: begin
                    if (eof) begin
                        raise_error(nkvl_pkg::ER_END);
                    end else if (c == nkvl_pkg::CH_UNDER || letter(c) || decimal(c)) begin
                        push_token(nkvl_pkg::EV_NAME_CHAR, c, nkvl_pkg::ER_NONE, lx_line);
                    end else if (blank(c) || c == nkvl_pkg::CH_LBRACE
                                 || c == nkvl_pkg::CH_RBRACE) begin
                        push_token(nkvl_pkg::EV_NAME_END, 8'd0, nkvl_pkg::ER_NONE, line_pre);
                        lx_mode = nkvl_pkg::M_WS;
                        lex_between(c, 1'b0);
                    end else begin
                        raise_error(nkvl_pkg::ER_CHAR);
                    end
                end
                nkvl_pkg::M_NUMBER: begin
                    if (!eof && (hexdig(c) || c == nkvl_pkg::CH_LOW_X
                                 || c == nkvl_pkg::CH_DOT || c == nkvl_pkg::CH_LOW_E
                                 || c == nkvl_pkg::CH_UP_E || c == nkvl_pkg::CH_PLUS
                                 || c == nkvl_pkg::CH_MINUS)) begin
                        push_token(nkvl_pkg::EV_NUM_CHAR, c, nkvl_pkg::ER_NONE, lx_line);
                    end else if (eof || blank(c) || c == nkvl_pkg::CH_LBRACE
                                 || c == nkvl_pkg::CH_RBRACE) begin
                        push_token(nkvl_pkg::EV_NUM_END, 8'd0, nkvl_pkg::ER_NONE, line_pre);
                        lx_mode = nkvl_pkg::M_WS;
                        lex_between(c, eof);
                    end else begin
                        raise_error(nkvl_pkg::ER_CHAR);
                    end
                end
                nkvl_pkg::M_STRING: begin
                    if (eof) begin
                        raise_error(nkvl_pkg::ER_END);
                    end else if (c == nkvl_pkg::CH_BSLASH) begin
                        lx_mode = nkvl_pkg::M_ESCAPE;
                        push_token(nkvl_pkg::EV_NONE, 8'd0, nkvl_pkg::ER_NONE, lx_line);
                    end else if (c == nkvl_pkg::CH_QUOTE) begin
                        lx_mode = nkvl_pkg::M_WS;
                        push_token(nkvl_pkg::EV_STR_CLOSE, 8'd0, nkvl_pkg::ER_NONE, lx_line);
                    end else if (c >= 8'h20 && c <= 8'h7E) begin
                        push_token(nkvl_pkg::EV_STR_CHAR, c, nkvl_pkg::ER_NONE, lx_line);
                    end else begin
                        raise_error(nkvl_pkg::ER_CHAR);
                    end
                end
                nkvl_pkg::M_ESCAPE: begin
                    decoded = 8'd0;
                    if (!eof && c == nkvl_pkg::CH_LOW_T) decoded = nkvl_pkg::CH_TAB;
                    else if (!eof && c == nkvl_pkg::CH_LOW_R) decoded = nkvl_pkg::CH_CR;
                    else if (!eof && c == nkvl_pkg::CH_LOW_N) decoded = nkvl_pkg::CH_LF;
                    else if (!eof && c == nkvl_pkg::CH_QUOTE) decoded = nkvl_pkg::CH_QUOTE;
                    else if (!eof && c == nkvl_pkg::CH_BSLASH) decoded = nkvl_pkg::CH_BSLASH;
                    if (decoded != 8'd0) begin
                        lx_mode = nkvl_pkg::M_STRING;
                        push_token(nkvl_pkg::EV_STR_CHAR, decoded, nkvl_pkg::ER_NONE, lx_line);
                    end else begin
                        raise_error(nkvl_pkg::ER_ESCAPE);
                    end
                end
                default: begin
                    lx_mode = nkvl_pkg::M_WS;
                    lex_between(c, eof);
                end
            endcase
        end
        pending_tokens[pending_tokens.size()-1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Result side: field-by-field check, then random or held-off tready
    // ------------------------------------------------------------------
    function automatic void field_check(input string fname, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s expected %0d actual %0d", fname, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_tokens.size() == 0) begin
                $error("unexpected result transfer, tdata %h", m_tdata);
                mismatches++;
            end else begin
                // tdata layout: event, data byte, error kind, line, depth
                want_tok = pending_tokens.pop_front();
                field_check("event_res", 32'(want_tok.ev), 32'(m_tdata[3:0]));
                field_check("data_byte", 32'(want_tok.data), 32'(m_tdata[11:4]));
                field_check("error_kind", 32'(want_tok.err), 32'(m_tdata[14:12]));
                field_check("line_number", 32'(want_tok.line), 32'(m_tdata[14+LINE_W:15]));
                field_check("depth", 32'(want_tok.depth),
                            32'(m_tdata[22+LINE_W:15+LINE_W]));
                field_check("last", 32'(want_tok.last), 32'(m_tlast));
                results_checked++;
            end
        end
    end

    // Receiver: a new hold-off request loads the counter; it runs down one per cycle
    always @(posedge aclk) begin
        if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (rx_stall_pct == 0) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Watchdog: ends the run when neither side has moved for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("nested_keyvalue_lexer test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    // One transfer. Valid stays high after acceptance so that back-to-back
    // calls stream without a bubble; stop_sending drops it.
    task automatic send_byte(input logic [7:0] c, input logic eof);
        int gap;
        gap = 0;
        while (tx_idle_pct != 0 && gap < 40 && $urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= c;
        s_tuser <= eof;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
        tokenize_byte(c, eof);
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
    endtask

    task automatic wait_drained();
        while (pending_tokens.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_idling(input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
    endtask

    // Register write only with nothing in flight
    task automatic write_max_depth(input logic [7:0] v);
        stop_sending();
        wait_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        lx_max = v;
    endtask

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(5))
            0: return nkvl_pkg::CH_SPACE;
            1: return nkvl_pkg::CH_TAB;
            2: return nkvl_pkg::CH_LF;
            3: return nkvl_pkg::CH_CR;
            4: return CH_VT;
            default: return CH_FF;
        endcase
    endfunction

    function automatic logic can_open();
        return lx_depth < lx_max && lx_depth < NEST_SOFT;
    endfunction

    // What may end a name or a number without an error
    function automatic logic [7:0] pick_delimiter();
        int r;
        r = $urandom_range(99);
        if (r < 20 && can_open()) return nkvl_pkg::CH_LBRACE;
        if (r < 40 && lx_depth > 0) return nkvl_pkg::CH_RBRACE;
        return pick_blank();
    endfunction

    // A byte that keeps the lexer out of done and error, with random content
    function automatic logic [7:0] next_safe_byte();
        int r;
        r = $urandom_range(99);
        case (lx_mode)
            nkvl_pkg::M_COMMENT: begin
                // any byte is comment text; LF or CR ends it
                if (r < 85) return 8'($urandom_range(255));
                return (r < 93) ? nkvl_pkg::CH_LF : nkvl_pkg::CH_CR;
            end
            nkvl_pkg::M_NAME: begin
                if (r < 75) return name_tail[$urandom_range(name_tail.len() - 1)];
                return pick_delimiter();
            end
            nkvl_pkg::M_NUMBER: begin
                if (r < 70) return num_tail[$urandom_range(num_tail.len() - 1)];
                return pick_delimiter();
            end
            nkvl_pkg::M_STRING: begin
                if (r < 8) return nkvl_pkg::CH_QUOTE;
                if (r < 16) return nkvl_pkg::CH_BSLASH;
                return 8'($urandom_range(8'h20, 8'h7E));
            end
            nkvl_pkg::M_ESCAPE: return esc_chars[$urandom_range(esc_chars.len() - 1)];
            default: begin
                if (r < 15) return pick_blank();
                if (r < 20) return nkvl_pkg::CH_HASH;
                if (r < 40) return name_head[$urandom_range(name_head.len() - 1)];
                if (r < 55) return num_head[$urandom_range(num_head.len() - 1)];
                if (r < 70) return nkvl_pkg::CH_QUOTE;
                if (r < 85) return can_open() ? nkvl_pkg::CH_LBRACE : pick_blank();
                return (lx_depth > 0) ? nkvl_pkg::CH_RBRACE : pick_blank();
            end
        endcase
    endfunction

    task automatic settle_to_blank();
        while (lx_mode != nkvl_pkg::M_WS) send_byte(next_safe_byte(), 1'b0);
    endtask

    task automatic run_random(input int n, input logic with_hold, input logic with_pause);
        for (int i = 0; i < n; i++) begin
            // receiver holds off while bytes keep coming, so the input backs up
            if (with_hold && i == n / 3) hold_reqs <= hold_reqs + 1;
            // sender waits until every result is in, then resumes
            if (with_pause && i == n / 2) begin
                stop_sending();
                wait_drained();
            end
            send_byte(next_safe_byte(), 1'b0);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Every event kind but done and error, all five escapes, CR/CRLF folding, comment with
    // extreme bytes, token ends on a brace and on a line end.
    task automatic test_directed();
        set_idling(0, 0);
        send_text("_Az9{\"\\t\\r\\n\\\"\\\\~\"x");
        send_byte(nkvl_pkg::CH_CR, 1'b0);
        send_byte(nkvl_pkg::CH_LF, 1'b0);
        send_byte(nkvl_pkg::CH_HASH, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(nkvl_pkg::CH_CR, 1'b0);
        send_text("q");
        send_byte(nkvl_pkg::CH_LF, 1'b0);
        send_text("+e.}");
    endtask

    // Nesting up to the full reset limit and back down
    task automatic test_deep_nesting();
        set_idling(14, 14);
        settle_to_blank();
        while (lx_depth < lx_max) send_byte(nkvl_pkg::CH_LBRACE, 1'b0);
        send_text("k ");
        while (lx_depth > 0) send_byte(nkvl_pkg::CH_RBRACE, 1'b0);
    endtask

    // Random well-formed text under each idling pattern and depth limit
    task automatic test_random_phases();
        set_idling(0, 0);
        run_random(200, 1'b1, 1'b0);
        write_max_depth(8'd1);
        set_idling(76, 0);
        run_random(200, 1'b0, 1'b0);
        write_max_depth(8'($urandom_range(2, 254)));
        set_idling(0, 76);
        run_random(200, 1'b0, 1'b1);
        write_max_depth(8'd255);
        set_idling(14, 14);
        run_random(200, 1'b0, 1'b0);
    endtask

    // One done or error case, then bytes that must repeat the sticky result
    task automatic test_terminal();
        logic [7:0] v;
        set_idling(14, 14);
        settle_to_blank();
        end_case = end_case_t'($urandom_range(END_TOO_DEEP));
        case (end_case)
            END_DONE: begin
                while (lx_depth > 0) send_byte(nkvl_pkg::CH_RBRACE, 1'b0);
                // half the time the end mark lands inside a comment
                if ($urandom_range(1)) send_text("#x");
                send_byte(8'($urandom_range(255)), 1'b1);
            end
            END_EOF_NESTED: begin
                if (lx_depth == 0) send_byte(nkvl_pkg::CH_LBRACE, 1'b0);
                send_byte(8'($urandom_range(255)), 1'b1);
            end
            END_EOF_NAME: begin
                send_text("k");
                send_byte(8'($urandom_range(255)), 1'b1);
            end
            END_EOF_NUMBER: begin
                if ($urandom_range(1)) begin
                    while (lx_depth > 0) send_byte(nkvl_pkg::CH_RBRACE, 1'b0);
                end
                send_text("7");
                send_byte(8'($urandom_range(255)), 1'b1);
            end
            END_EOF_STRING: begin
                send_text("\"a");
                send_byte(8'($urandom_range(255)), 1'b1);
            end
            END_EOF_ESCAPE: begin
                send_text("\"\\");
                send_byte(8'($urandom_range(255)), 1'b1);
            end
            END_BAD_ESCAPE: send_text("\"\\q");
            END_STRING_CTRL: begin
                send_text("\"");
                v = $urandom_range(1) ? 8'($urandom_range(31)) : 8'($urandom_range(127, 255));
                send_byte(v, 1'b0);
            end
            END_WS_CHAR: begin
                if ($urandom_range(1)) v = stray_chars[$urandom_range(stray_chars.len() - 1)];
                else v = 8'($urandom_range(128, 255));
                send_byte(v, 1'b0);
            end
            END_TOKEN_CHAR: begin
                send_text($urandom_range(1) ? "k" : "5");
                send_byte(stray_chars[$urandom_range(stray_chars.len() - 1)], 1'b0);
            end
            END_UNBALANCED: begin
                while (lx_depth > 0) send_byte(nkvl_pkg::CH_RBRACE, 1'b0);
                send_byte(nkvl_pkg::CH_RBRACE, 1'b0);
            end
            default: begin
                // limit of zero overflows on the first brace
                case ($urandom_range(3))
                    0: v = 8'd0;
                    1: v = 8'd1;
                    2: v = 8'd255;
                    default: v = 8'($urandom_range(2, 254));
                endcase
                write_max_depth(v);
                while (lx_mode != nkvl_pkg::M_ERROR) send_byte(nkvl_pkg::CH_LBRACE, 1'b0);
            end
        endcase
        repeat (8) send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_deep_nesting();
        test_random_phases();
        test_terminal();

        stop_sending();
        wait_drained();
        repeat (10) @(posedge aclk);

        $display("Lexed %0d bytes into %0d checked events across four idling patterns,",
                 bytes_sent, results_checked);
        $display("depth limits 0..255 and full nesting; ending: %s",
                 end_case.name());
        if (mismatches == 0) begin
            $display("nested_keyvalue_lexer test passed");
        end else begin
            $display("nested_keyvalue_lexer test failed");
        end
        $finish;
    end

endmodule
